### rtl/jafc_pkg.sv
// Shared definitions for the joystick axis filter and calibrate unit.
// Holds register index codes, reset values, limits and the lane handshake structs.
// No dependencies.
`timescale 1ns / 1ps

package jafc_pkg;

    // Default widths of the sample and position fields.
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int OUT_BITS_DEF    = 15;

    // Configuration port index width and register index codes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_X_LOW_CAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_HIGH_CAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LOW_CAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH_CAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_X     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_Y     = 3'd6;

    // Smoothing shift limits.
    localparam int SHIFT_W = 3;
    localparam logic [SHIFT_W-1:0] MAX_SHIFT     = 3'd6;
    localparam logic [SHIFT_W-1:0] DEFAULT_SHIFT = 3'd2;

    // Calibration reset values and the narrow window margin.
    localparam int CAL_LOW_RESET  = 120;
    localparam int CAL_HIGH_RESET = 3975;
    localparam int NARROW_MARGIN  = 10;

    // Control from the merge stage to one axis lane.
    typedef struct packed {
        logic               start;
        logic               primed;
        logic               ack;
        logic [SHIFT_W-1:0] shift;
    } lane_ctrl_t;

    // Status from one axis lane back to the merge stage.
    typedef struct packed {
        logic busy;
        logic done;
    } lane_stat_t;

endpackage

### rtl/jafc_divider.sv
// Restoring serial divider, one quotient bit per cycle, used by each axis lane.
// Depends on jafc_pkg for the default widths.
`timescale 1ns / 1ps

module jafc_divider
    import jafc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int OUT_BITS    = OUT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [SAMPLE_BITS+OUT_BITS-1:0] dividend,
    input  logic [SAMPLE_BITS-1:0]          divisor,
    output logic                            done,
    output logic [OUT_BITS-1:0]             quotient
);

    localparam int CNT_W = $clog2(OUT_BITS + 1);
    localparam logic [CNT_W-1:0] STEPS    = CNT_W'(OUT_BITS);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [SAMPLE_BITS-1:0] rem_reg;
    logic [SAMPLE_BITS-1:0] rem_next;
    logic [SAMPLE_BITS-1:0] div_reg;
    logic [OUT_BITS-1:0]    quo_reg;
    logic [SAMPLE_BITS:0]   trial;
    logic                   fits;

    // One restoring step: bring down the next dividend bit and try the subtract.
    // The caller guarantees the upper dividend part is below the divisor, so the
    // quotient fits in OUT_BITS and the remainder in SAMPLE_BITS.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[OUT_BITS-1]};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? SAMPLE_BITS'(trial - {1'b0, div_reg}) : trial[SAMPLE_BITS-1:0];
    end

    // Control: step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - LAST_CNT;
                if (cnt_reg == LAST_CNT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and the dividend bits that turn into quotient bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[SAMPLE_BITS+OUT_BITS-1:OUT_BITS];
            quo_reg <= dividend[OUT_BITS-1:0];
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[OUT_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/jafc_lane.sv
// One axis lane: smoothing filter, window clamp, scaling through a serial divider
// and the optional mirror. Depends on jafc_pkg and jafc_divider.
`timescale 1ns / 1ps

module jafc_lane
    import jafc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int OUT_BITS    = OUT_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lane_ctrl_t             ctrl,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] low_cal,
    input  logic [SAMPLE_BITS-1:0] high_cal,
    input  logic                   flip,
    output lane_stat_t             stat,
    output logic [OUT_BITS-1:0]    position
);

    localparam int DIV_W = SAMPLE_BITS + OUT_BITS;
    localparam logic [OUT_BITS-1:0] FULL = '1;
    localparam logic [OUT_BITS-1:0] HALF = FULL >> 1;
    localparam logic [SAMPLE_BITS:0] MARGIN = (SAMPLE_BITS+1)'(NARROW_MARGIN);

    localparam logic [2:0] L_IDLE  = 3'd0;
    localparam logic [2:0] L_CLAMP = 3'd1;
    localparam logic [2:0] L_DIVS  = 3'd2;
    localparam logic [2:0] L_DIVW  = 3'd3;
    localparam logic [2:0] L_DONE  = 3'd4;

    logic [2:0]              state_reg;
    logic [SAMPLE_BITS-1:0]  smoothed_reg;
    logic [SAMPLE_BITS-1:0]  smoothed_next;
    logic [SAMPLE_BITS-1:0]  n_reg;
    logic [SAMPLE_BITS-1:0]  d_reg;
    logic                    narrow_reg;
    logic [OUT_BITS-1:0]     pos_reg;

    logic signed [SAMPLE_BITS:0] diff;
    logic signed [SAMPLE_BITS:0] step;
    logic [SAMPLE_BITS:0]        sum;
    logic [SAMPLE_BITS-1:0]      v_lo;
    logic [SAMPLE_BITS-1:0]      v_clamped;
    logic                        narrow;
    logic [DIV_W-1:0]            dividend;
    logic                        div_start;
    logic                        div_done;
    logic [OUT_BITS-1:0]         quotient;

    // Filter update: the arithmetic shift floors a negative error.
    always_comb
    begin
        diff          = $signed({1'b0, sample}) - $signed({1'b0, smoothed_reg});
        step          = diff >>> ctrl.shift;
        sum           = {1'b0, smoothed_reg} + $unsigned(step);
        smoothed_next = ctrl.primed ? sum[SAMPLE_BITS-1:0] : sample;
    end

    // Clamp to the calibration window and detect a window too narrow to scale.
    always_comb
    begin
        v_lo      = (smoothed_reg < low_cal) ? low_cal : smoothed_reg;
        v_clamped = (v_lo > high_cal) ? high_cal : v_lo;
        narrow    = ({1'b0, high_cal} <= ({1'b0, low_cal} + MARGIN));
    end

    // n * FULL with FULL = 2^OUT_BITS - 1, done as a shift and a subtract.
    assign dividend  = {n_reg, {OUT_BITS{1'b0}}} - DIV_W'(n_reg);
    assign div_start = (state_reg == L_DIVS) && !narrow_reg;

    jafc_divider #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .OUT_BITS    (OUT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (d_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Lane sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= L_IDLE;
            smoothed_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                L_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        smoothed_reg <= smoothed_next;
                        state_reg    <= L_CLAMP;
                    end
                end
                L_CLAMP:
                begin
                    state_reg <= L_DIVS;
                end
                L_DIVS:
                begin
                    state_reg <= narrow_reg ? L_DONE : L_DIVW;
                end
                L_DIVW:
                begin
                    if (div_done)
                    begin
                        state_reg <= L_DONE;
                    end
                end
                L_DONE:
                begin
                    if (ctrl.ack)
                    begin
                        state_reg <= L_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    // Scaling datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == L_CLAMP)
        begin
            n_reg      <= v_clamped - low_cal;
            d_reg      <= high_cal - low_cal;
            narrow_reg <= narrow;
        end
        if ((state_reg == L_DIVS) && narrow_reg)
        begin
            pos_reg <= HALF;
        end
        else if ((state_reg == L_DIVW) && div_done)
        begin
            pos_reg <= flip ? (FULL - quotient) : quotient;
        end
    end

    assign stat.busy = (state_reg != L_IDLE);
    assign stat.done = (state_reg == L_DONE);
    assign position  = pos_reg;

endmodule

### rtl/joystick_axis_filter_calibrate_unit.sv
// Top level of the joystick axis filter and calibrate unit: configuration
// registers, the two axis lanes and the merge stage. Depends on jafc_pkg and jafc_lane.
`timescale 1ns / 1ps

// Each transfer carries one X/Y sample pair and yields one X/Y position pair.
// The two axes run in parallel lanes, each with its own smoothing filter and
// a serial divider that scales the clamped value to 0..2^OUT_BITS-1. Each item goes
// through the clamp, divider start, divide (skipped for a narrow window) and done
// states of both lanes before the next input is taken; the one-bit-per-cycle divider
// in each lane sets the pace. The result waits in an output register, so a new
// item may enter while the previous result is still stalled. The first item after
// reset loads the filters directly. The user must write the calibration, shift and
// mirror registers through the plain write port only while idle; not enforced.
module joystick_axis_filter_calibrate_unit
    import jafc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int OUT_BITS    = OUT_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [SAMPLE_BITS-1:0] cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample_x,
    input  logic [SAMPLE_BITS-1:0] sample_y,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [OUT_BITS-1:0]    position_x,
    output logic [OUT_BITS-1:0]    position_y
);

    logic [SAMPLE_BITS-1:0] x_low_cal_reg;
    logic [SAMPLE_BITS-1:0] x_high_cal_reg;
    logic [SAMPLE_BITS-1:0] y_low_cal_reg;
    logic [SAMPLE_BITS-1:0] y_high_cal_reg;
    logic [SHIFT_W-1:0]     shift_reg;
    logic                   flip_x_reg;
    logic                   flip_y_reg;
    logic                   primed_reg;
    logic                   out_valid_reg;
    logic [OUT_BITS-1:0]    pos_x_reg;
    logic [OUT_BITS-1:0]    pos_y_reg;

    lane_ctrl_t          lane_ctrl;
    lane_stat_t          x_stat;
    lane_stat_t          y_stat;
    logic [OUT_BITS-1:0] lane_pos_x;
    logic [OUT_BITS-1:0] lane_pos_y;
    logic                accept;
    logic                merge;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_cal_reg  <= SAMPLE_BITS'(CAL_LOW_RESET);
            x_high_cal_reg <= SAMPLE_BITS'(CAL_HIGH_RESET);
            y_low_cal_reg  <= SAMPLE_BITS'(CAL_LOW_RESET);
            y_high_cal_reg <= SAMPLE_BITS'(CAL_HIGH_RESET);
            shift_reg      <= DEFAULT_SHIFT;
            flip_x_reg     <= 1'b0;
            flip_y_reg     <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_X_LOW_CAL:  x_low_cal_reg  <= cfg_data;
                REG_X_HIGH_CAL: x_high_cal_reg <= cfg_data;
                REG_Y_LOW_CAL:  y_low_cal_reg  <= cfg_data;
                REG_Y_HIGH_CAL: y_high_cal_reg <= cfg_data;
                REG_SHIFT:      shift_reg      <= cfg_data[SHIFT_W-1:0];
                REG_FLIP_X:     flip_x_reg     <= cfg_data[0];
                REG_FLIP_Y:     flip_y_reg     <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Input transfer and lane control; an out-of-range shift acts as the default.
    assign in_stall = x_stat.busy || y_stat.busy;
    assign accept   = in_valid && !in_stall;
    assign merge    = x_stat.done && y_stat.done && (!out_valid_reg || !out_stall);

    always_comb
    begin
        lane_ctrl.start  = accept;
        lane_ctrl.primed = primed_reg;
        lane_ctrl.ack    = merge;
        lane_ctrl.shift  = (shift_reg > MAX_SHIFT) ? DEFAULT_SHIFT : shift_reg;
    end

    jafc_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .OUT_BITS    (OUT_BITS)
    ) u_lane_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (lane_ctrl),
        .sample   (sample_x),
        .low_cal  (x_low_cal_reg),
        .high_cal (x_high_cal_reg),
        .flip     (flip_x_reg),
        .stat     (x_stat),
        .position (lane_pos_x)
    );

    jafc_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .OUT_BITS    (OUT_BITS)
    ) u_lane_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (lane_ctrl),
        .sample   (sample_y),
        .low_cal  (y_low_cal_reg),
        .high_cal (y_high_cal_reg),
        .flip     (flip_y_reg),
        .stat     (y_stat),
        .position (lane_pos_y)
    );

    // Merge stage: both lanes finished, move the pair into the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                primed_reg <= 1'b1;
            end
            if (merge)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (merge)
        begin
            pos_x_reg <= lane_pos_x;
            pos_y_reg <= lane_pos_y;
        end
    end

    assign out_valid  = out_valid_reg;
    assign position_x = pos_x_reg;
    assign position_y = pos_y_reg;

`ifndef ASSERT_OFF
    // A transfer starts both lanes together.
    a_start_both: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (x_stat.busy && y_stat.busy))
        else $error("lanes did not both start on an input transfer");

    // A merge frees both lanes and presents a result.
    a_merge_frees: assert property (@(posedge clk) disable iff (!rst_n)
        merge |=> (out_valid_reg && !x_stat.busy && !y_stat.busy))
        else $error("merge did not release lanes or present a result");

    // A new result appears only from a merge of two finished lanes.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(x_stat.done && y_stat.done))
        else $error("result appeared without both lanes done");

    // The filters are loaded by the first transfer before any result exists.
    a_primed_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> primed_reg)
        else $error("result present before the filters were loaded");
`endif

endmodule
